// ===== rtl/actuator_position_supervisor_top_macros.svh =====
// assertion macros shared by the supervisor modules
// no dependencies; included by the files that check their own logic
`ifndef ACTUATOR_POSITION_SUPERVISOR_TOP_MACROS_SVH
`define ACTUATOR_POSITION_SUPERVISOR_TOP_MACROS_SVH

// same-cycle implication
`define APS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aps: same-cycle check failed");

// next-cycle implication
`define APS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aps: next-cycle check failed");

// implication after a fixed number of cycles
`define APS_ASSERT_DLY(lbl, clk, rst_n, ante, dly, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("aps: delayed check failed");

`endif

// ===== rtl/aps_pkg.sv =====
// types and constants of the actuator position supervisor
// no dependencies; used by the interfaces and every module
package aps_pkg;

    localparam int unsigned POS_W     = 8;
    localparam int unsigned FAULT_W   = 4;
    localparam int unsigned RUN_W     = 18;
    localparam int unsigned ID_W      = 29;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned DIV_STEPS = POS_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_POS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_POS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RET_DELAY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_ADDR  = 3'd5;

    localparam logic [POS_W-1:0] RST_MAX_POS   = 8'd100;
    localparam logic [POS_W-1:0] RST_MIN_POS   = 8'd0;
    localparam logic [POS_W-1:0] RST_TOLERANCE = 8'd3;
    localparam logic [POS_W-1:0] RST_SPEED     = 8'd5;
    localparam logic [POS_W-1:0] RST_RET_DELAY = 8'd5;
    localparam logic [POS_W-1:0] RST_SRC_ADDR  = 8'd72;

    // drive codes
    localparam logic [1:0] DRV_OFF     = 2'd0;
    localparam logic [1:0] DRV_EXTEND  = 2'd1;
    localparam logic [1:0] DRV_RETRACT = 2'd2;

    // fault codes
    localparam logic [2:0] FC_NONE     = 3'd0;
    localparam logic [2:0] FC_OVER_MAX = 3'd1;
    localparam logic [2:0] FC_UNDER_MIN = 3'd2;
    localparam logic [2:0] FC_LINE0    = 3'd4;
    localparam logic [2:0] FC_LINE1    = 3'd5;
    localparam logic [2:0] FC_LINE2    = 3'd6;
    localparam logic [2:0] FC_LINE3    = 3'd7;

    // parameter codes
    localparam logic [1:0] PC_NONE  = 2'd0;
    localparam logic [1:0] PC_RANGE = 2'd1;
    localparam logic [1:0] PC_DRIVE = 2'd2;
    localparam logic [1:0] PC_POWER = 2'd3;

    localparam logic [15:0] PARAM_RANGE = 16'd190;
    localparam logic [15:0] PARAM_DRIVE = 16'd168;
    localparam logic [15:0] PARAM_POWER = 16'h0434;

    // identifier bits above the source address
    localparam logic [ID_W-POS_W-1:0] ID_HI_STATUS = {3'd1, 2'b00, 8'hF0, 8'h32};
    localparam logic [ID_W-POS_W-1:0] ID_HI_FAULT  = {3'd6, 2'b00, 8'hFE, 8'hCA};
    localparam logic [POS_W-1:0] STATUS_BYTE1 = 8'hBF;
    localparam logic [POS_W-1:0] STATUS_BYTE2 = 8'h16;

    localparam logic [RUN_W-1:0] RUN_SCALE = 18'd1000;

    typedef struct packed {
        logic capture;
        logic eval;
        logic div_step;
        logic scale;
        logic publish;
    } t_dp_cmd;

endpackage

// ===== rtl/aps_ifs.sv =====
// item channels and configuration write channel of the supervisor
// depends on aps_pkg
interface aps_in_if;
    logic                          valid;
    logic                          ready;
    logic                          new_command;
    logic [aps_pkg::POS_W-1:0]     target_position;
    logic [aps_pkg::POS_W-1:0]     sensor_position;
    logic [aps_pkg::FAULT_W-1:0]   fault_inputs;

    modport source (output valid, new_command, target_position, sensor_position,
                    fault_inputs, input ready);
    modport sink (input valid, new_command, target_position, sensor_position,
                  fault_inputs, output ready);
endinterface

interface aps_out_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  drive;
    logic [aps_pkg::RUN_W-1:0]   run_ms;
    logic                        home_lamp;
    logic                        alarm;
    logic [aps_pkg::ID_W-1:0]    message_id;
    logic [aps_pkg::POS_W-1:0]   message_byte0;
    logic [aps_pkg::POS_W-1:0]   message_byte1;
    logic [aps_pkg::POS_W-1:0]   message_byte2;

    modport source (output valid, drive, run_ms, home_lamp, alarm, message_id,
                    message_byte0, message_byte1, message_byte2, input ready);
    modport sink (input valid, drive, run_ms, home_lamp, alarm, message_id,
                  message_byte0, message_byte1, message_byte2, output ready);
endinterface

interface aps_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [aps_pkg::CFG_IDX_W-1:0]   index;
    logic [aps_pkg::POS_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/actuator_position_supervisor_top.sv =====
// Actuator position supervisor: one item per control tick gives one result item with
// the drive direction, run time, home lamp, alarm and a status or fault message.
// An item runs from acceptance to its result in the output register through capture,
// evaluate, 8 steps of a one-bit-per-cycle restoring divider for distance over speed,
// scale by 1000 and publish, which waits while the output register holds an unaccepted
// result. A new item is accepted as soon as the previous result sits in the output
// register. Settings are written through the configuration channel, which is always
// ready, only while no item is in work: a user rule that the block does not enforce.
// Depends on aps_pkg, the channel interfaces, aps_ctrl and aps_dp.
module actuator_position_supervisor_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    aps_in_if.sink    i_in,
    aps_cfg_if.sink   i_cfg,
    aps_out_if.source o_res
);
    aps_pkg::t_dp_cmd cmd;
    logic             in_ready;
    logic             out_valid;

    aps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_res.ready),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    aps_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_cfg_we          (i_cfg.valid),
        .i_cfg_idx         (i_cfg.index),
        .i_cfg_data        (i_cfg.data),
        .i_new_command     (i_in.new_command),
        .i_target_position (i_in.target_position),
        .i_sensor_position (i_in.sensor_position),
        .i_fault_inputs    (i_in.fault_inputs),
        .o_drive           (o_res.drive),
        .o_run_ms          (o_res.run_ms),
        .o_home_lamp       (o_res.home_lamp),
        .o_alarm           (o_res.alarm),
        .o_message_id      (o_res.message_id),
        .o_message_byte0   (o_res.message_byte0),
        .o_message_byte1   (o_res.message_byte1),
        .o_message_byte2   (o_res.message_byte2)
    );

    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = out_valid;

endmodule

// ===== rtl/aps_ctrl.sv =====
// sequencer of the supervisor: capture, evaluate, divide, scale, publish
// depends on aps_pkg and the assertion macro header
`include "actuator_position_supervisor_top_macros.svh"

module aps_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_ready,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output aps_pkg::t_dp_cmd o_cmd
);
    localparam int unsigned CNT_W = $clog2(aps_pkg::DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(aps_pkg::DIV_STEPS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_DIV,
        S_SCALE,
        S_PUBLISH
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_cnt      = '0;
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_PUBLISH;
            end
            S_PUBLISH: begin
                if (out_free) begin
                    o_cmd.publish = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `APS_ASSERT_IMP(a_publish_free, i_clk, i_rst_n, o_cmd.publish, out_free)
    `APS_ASSERT_NXT(a_capture_eval, i_clk, i_rst_n, i_in_valid && o_in_ready, o_cmd.eval)
    `APS_ASSERT_DLY(a_div_length, i_clk, i_rst_n, o_cmd.eval, 9, o_cmd.scale)
    `APS_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, o_in_ready, !o_cmd.div_step && !o_cmd.scale)

endmodule

// ===== rtl/aps_dp.sv =====
// datapath of the supervisor: settings, servo state, divider, scaler, result register
// depends on aps_pkg
module aps_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  aps_pkg::t_dp_cmd              i_cmd,
    input  logic                          i_cfg_we,
    input  logic [aps_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [aps_pkg::POS_W-1:0]     i_cfg_data,
    input  logic                          i_new_command,
    input  logic [aps_pkg::POS_W-1:0]     i_target_position,
    input  logic [aps_pkg::POS_W-1:0]     i_sensor_position,
    input  logic [aps_pkg::FAULT_W-1:0]   i_fault_inputs,
    output logic [1:0]                    o_drive,
    output logic [aps_pkg::RUN_W-1:0]     o_run_ms,
    output logic                          o_home_lamp,
    output logic                          o_alarm,
    output logic [aps_pkg::ID_W-1:0]      o_message_id,
    output logic [aps_pkg::POS_W-1:0]     o_message_byte0,
    output logic [aps_pkg::POS_W-1:0]     o_message_byte1,
    output logic [aps_pkg::POS_W-1:0]     o_message_byte2
);
    localparam int unsigned PW = aps_pkg::POS_W;
    localparam int unsigned EW = PW + 2;

    // settings
    logic [PW-1:0] r_max, r_min, r_tol, r_speed, r_rdly, r_src;

    // servo state
    logic [PW-1:0] r_idle, r_held;
    logic          r_keep, r_derr, r_lamp;
    logic [2:0]    r_fc;
    logic [1:0]    r_pc;

    // captured item
    logic                       r_cmd;
    logic [PW-1:0]              r_tgt, r_sns;
    logic [aps_pkg::FAULT_W-1:0] r_flt;

    // work registers
    logic [1:0]               r_drv;
    logic                     r_alarm;
    logic [PW-1:0]            r_quo;
    logic [PW-1:0]            r_rem;
    logic [aps_pkg::RUN_W-1:0] r_run;
    logic [aps_pkg::ID_W-1:0] r_id;
    logic [PW-1:0]            r_b0, r_b1, r_b2;

    // result register
    logic [1:0]               r_o_drv;
    logic [aps_pkg::RUN_W-1:0] r_o_run;
    logic                     r_o_lamp, r_o_alarm;
    logic [aps_pkg::ID_W-1:0] r_o_id;
    logic [PW-1:0]            r_o_b0, r_o_b1, r_o_b2;

    // evaluation
    logic [PW-1:0] n_idle, n_held;
    logic          n_keep, n_derr, n_lamp;
    logic [2:0]    n_fc;
    logic [1:0]    n_pc;
    logic [1:0]    n_drv;
    logic [PW-1:0] n_dist;
    logic          alarm;
    logic signed [EW-1:0] err_c, err_h, neg_c, neg_h, tol_p, tol_n;
    logic          above_c, below_c, above_h, below_h, off_c, off_h;
    logic [15:0]   param;
    logic [aps_pkg::ID_W-1:0] n_id;
    logic [PW-1:0] n_b0, n_b1, n_b2;

    // divider step
    logic [PW:0]   rem_sh;
    logic          fits;

    assign alarm   = |r_flt;
    assign err_c   = EW'({2'b00, r_tgt}) - EW'({2'b00, r_sns});
    assign err_h   = EW'({2'b00, r_held}) - EW'({2'b00, r_sns});
    assign neg_c   = -err_c;
    assign neg_h   = -err_h;
    assign tol_p   = EW'({2'b00, r_tol});
    assign tol_n   = -tol_p;
    assign above_c = err_c > tol_p;
    assign below_c = err_c < tol_n;
    assign above_h = err_h > tol_p;
    assign below_h = err_h < tol_n;
    assign off_c   = above_c || below_c;
    assign off_h   = above_h || below_h;

    always_comb begin
        n_idle = r_idle;
        n_held = r_held;
        n_keep = r_keep;
        n_derr = r_derr;
        n_lamp = r_lamp;
        n_fc   = r_fc;
        n_pc   = r_pc;
        n_drv  = aps_pkg::DRV_OFF;
        n_dist = '0;
        if (r_cmd) begin
            n_idle = '0;
            n_held = r_tgt;
            if (above_c) begin
                if (r_tgt > r_max) begin
                    n_derr = 1'b1;
                    n_fc   = aps_pkg::FC_OVER_MAX;
                    n_pc   = aps_pkg::PC_RANGE;
                end else begin
                    n_derr = 1'b0;
                    n_drv  = aps_pkg::DRV_EXTEND;
                    n_dist = err_c[PW-1:0];
                    n_keep = off_c;
                end
            end else if (below_c) begin
                if (r_tgt < r_min) begin
                    n_derr = 1'b1;
                    n_fc   = aps_pkg::FC_UNDER_MIN;
                    n_pc   = aps_pkg::PC_RANGE;
                end else begin
                    n_derr = 1'b0;
                    n_drv  = aps_pkg::DRV_RETRACT;
                    n_dist = neg_c[PW-1:0];
                    n_keep = off_c;
                end
            end else begin
                n_derr = 1'b0;
                n_keep = off_c;
            end
        end else if (!r_keep && !alarm && !r_derr) begin
            if (r_idle == r_rdly) begin
                n_idle = '0;
                n_lamp = 1'b1;
                if (r_sns > r_tol && !off_h) begin
                    n_held = '0;
                    n_drv  = aps_pkg::DRV_RETRACT;
                    n_dist = r_sns;
                end
            end else begin
                n_lamp = 1'b0;
                n_idle = r_idle + 1'b1;
            end
        end else if (r_keep && !alarm && !r_derr) begin
            n_idle = '0;
            if (above_h) begin
                n_drv  = aps_pkg::DRV_EXTEND;
                n_dist = err_h[PW-1:0];
            end else if (below_h) begin
                n_drv  = aps_pkg::DRV_RETRACT;
                n_dist = neg_h[PW-1:0];
            end
            n_keep = off_h;
        end else begin
            n_idle = '0;
            n_keep = off_h;
        end

        // fault lines, lowest bit first
        if (r_flt[0]) begin
            n_fc = aps_pkg::FC_LINE0;
            n_pc = aps_pkg::PC_DRIVE;
        end else if (r_flt[1]) begin
            n_fc = aps_pkg::FC_LINE1;
            n_pc = aps_pkg::PC_DRIVE;
        end else if (r_flt[2]) begin
            n_fc = aps_pkg::FC_LINE2;
            n_pc = aps_pkg::PC_POWER;
        end else if (r_flt[3]) begin
            n_fc = aps_pkg::FC_LINE3;
            n_pc = aps_pkg::PC_POWER;
        end

        case (n_pc)
            aps_pkg::PC_RANGE: param = aps_pkg::PARAM_RANGE;
            aps_pkg::PC_DRIVE: param = aps_pkg::PARAM_DRIVE;
            aps_pkg::PC_POWER: param = aps_pkg::PARAM_POWER;
            default:           param = '0;
        endcase

        if (!alarm && !n_derr) begin
            n_id = {aps_pkg::ID_HI_STATUS, r_src};
            n_b0 = r_sns;
            n_b1 = aps_pkg::STATUS_BYTE1;
            n_b2 = aps_pkg::STATUS_BYTE2;
        end else begin
            n_id = {aps_pkg::ID_HI_FAULT, r_src};
            n_b0 = {{(PW-3){1'b0}}, n_fc};
            n_b1 = param[7:0];
            n_b2 = param[15:8];
        end
    end

    assign rem_sh = {r_rem, r_quo[PW-1]};
    assign fits   = rem_sh >= {1'b0, r_speed};

    // settings and servo state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max  <= aps_pkg::RST_MAX_POS;
            r_min  <= aps_pkg::RST_MIN_POS;
            r_tol  <= aps_pkg::RST_TOLERANCE;
            r_speed <= aps_pkg::RST_SPEED;
            r_rdly <= aps_pkg::RST_RET_DELAY;
            r_src  <= aps_pkg::RST_SRC_ADDR;
            r_idle <= '0;
            r_held <= '0;
            r_keep <= 1'b0;
            r_derr <= 1'b0;
            r_lamp <= 1'b0;
            r_fc   <= aps_pkg::FC_NONE;
            r_pc   <= aps_pkg::PC_NONE;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    aps_pkg::REG_MAX_POS:   r_max   <= i_cfg_data;
                    aps_pkg::REG_MIN_POS:   r_min   <= i_cfg_data;
                    aps_pkg::REG_TOLERANCE: r_tol   <= i_cfg_data;
                    aps_pkg::REG_SPEED:     r_speed <= i_cfg_data;
                    aps_pkg::REG_RET_DELAY: r_rdly  <= i_cfg_data;
                    aps_pkg::REG_SRC_ADDR:  r_src   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.eval) begin
                r_idle <= n_idle;
                r_held <= n_held;
                r_keep <= n_keep;
                r_derr <= n_derr;
                r_lamp <= n_lamp;
                r_fc   <= n_fc;
                r_pc   <= n_pc;
            end
        end
    end

    // payload path
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd <= i_new_command;
            r_tgt <= i_target_position;
            r_sns <= i_sensor_position;
            r_flt <= i_fault_inputs;
        end
        if (i_cmd.eval) begin
            r_drv   <= n_drv;
            r_alarm <= alarm;
            r_quo   <= n_dist;
            r_rem   <= '0;
            r_id    <= n_id;
            r_b0    <= n_b0;
            r_b1    <= n_b1;
            r_b2    <= n_b2;
        end
        if (i_cmd.div_step) begin
            r_rem <= fits ? rem_sh[PW-1:0] - r_speed : rem_sh[PW-1:0];
            r_quo <= {r_quo[PW-2:0], fits};
        end
        if (i_cmd.scale) begin
            if (r_drv != aps_pkg::DRV_OFF && !r_alarm && r_speed != '0) begin
                r_run <= {{(aps_pkg::RUN_W-PW){1'b0}}, r_quo} * aps_pkg::RUN_SCALE;
            end else begin
                r_run <= '0;
            end
        end
        if (i_cmd.publish) begin
            r_o_drv   <= r_drv;
            r_o_run   <= r_run;
            r_o_lamp  <= r_lamp;
            r_o_alarm <= r_alarm;
            r_o_id    <= r_id;
            r_o_b0    <= r_b0;
            r_o_b1    <= r_b1;
            r_o_b2    <= r_b2;
        end
    end

    assign o_drive         = r_o_drv;
    assign o_run_ms        = r_o_run;
    assign o_home_lamp     = r_o_lamp;
    assign o_alarm         = r_o_alarm;
    assign o_message_id    = r_o_id;
    assign o_message_byte0 = r_o_b0;
    assign o_message_byte1 = r_o_b1;
    assign o_message_byte2 = r_o_b2;

endmodule
